### hw/rtl/avt_pkg.sv
// Shared types, widths and codes of the affine vertex transform block.
package avt_pkg;

	localparam int CoordW      = 24;
	localparam int GainW       = 16;
	localparam int FracW       = 12;
	localparam int ProdW       = CoordW + GainW;
	localparam int AccW        = ProdW + 2;
	localparam int SumW        = 45;
	localparam int MaxVertices = 1048576;
	localparam int CntW        = $clog2(MaxVertices + 1);
	localparam int CfgIdxW     = 3;
	localparam int CfgDataW    = 3 * GainW;
	localparam int DataW       = 3 * CoordW;
	localparam int KindW       = 2;
	localparam int FifoDepth   = 4;
	localparam int FifoPtrW    = $clog2(FifoDepth);
	localparam int GainOne     = 4096;

	localparam logic [KindW-1:0] KindVertex = 2'd0;
	localparam logic [KindW-1:0] KindMin    = 2'd1;
	localparam logic [KindW-1:0] KindMax    = 2'd2;
	localparam logic [KindW-1:0] KindMean   = 2'd3;

	localparam logic [CfgIdxW-1:0] RegRowX = 3'd0;
	localparam logic [CfgIdxW-1:0] RegRowY = 3'd1;
	localparam logic [CfgIdxW-1:0] RegRowZ = 3'd2;
	localparam logic [CfgIdxW-1:0] RegOffX = 3'd3;
	localparam logic [CfgIdxW-1:0] RegOffY = 3'd4;
	localparam logic [CfgIdxW-1:0] RegOffZ = 3'd5;

	typedef logic signed [CoordW-1:0] coord_t;

	localparam coord_t CoordMax = coord_t'((2 ** (CoordW - 1)) - 1);
	localparam coord_t CoordMin = coord_t'(-(2 ** (CoordW - 1)));

	typedef struct packed {
		logic   last;
		coord_t z;
		coord_t y;
		coord_t x;
	} vtx_t;

	typedef struct packed {
		logic                  start;
		logic [CntW-1:0]       count;
	} div_req_t;

endpackage

### hw/rtl/avt_xform.sv
// Front end: accepts vertices and runs the three-stage affine transform pipeline.
module avt_xform (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [2:0][avt_pkg::CfgDataW-1:0]     gains,
	input  logic [2:0][avt_pkg::CoordW-1:0]       offs,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  avt_pkg::vtx_t                         in_vtx,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output avt_pkg::vtx_t                         out_vtx
);

	localparam int QW = avt_pkg::AccW - avt_pkg::FracW;
	localparam logic signed [QW-1:0] QMax = QW'(avt_pkg::CoordMax);
	localparam logic signed [QW-1:0] QMin = QW'(avt_pkg::CoordMin);

	logic signed [avt_pkg::GainW-1:0]  gain_c [3][3];
	logic signed [avt_pkg::CoordW-1:0] coord_c [3];
	logic signed [avt_pkg::CoordW-1:0] off_c [3];
	logic signed [avt_pkg::AccW-1:0]   rnd_c [3];
	logic signed [QW-1:0]              shr_c [3];
	avt_pkg::coord_t                   sat_c [3];
	logic                              advance;

	logic                              v_s1, v_s2, v_s3;
	logic                              last_s1, last_s2;
	logic signed [avt_pkg::ProdW-1:0]  prod_s1 [3][3];
	logic signed [avt_pkg::AccW-1:0]   acc_s2 [3];
	avt_pkg::vtx_t                     res_s3;

	assign advance   = !v_s3 || out_ready;
	assign in_ready  = advance;
	assign out_valid = v_s3;
	assign out_vtx   = res_s3;

	always_comb begin
		coord_c[0] = in_vtx.x;
		coord_c[1] = in_vtx.y;
		coord_c[2] = in_vtx.z;
		for (int r = 0; r < 3; r++) begin
			off_c[r] = offs[r];
			for (int k = 0; k < 3; k++) begin
				gain_c[r][k] = gains[r][avt_pkg::GainW*k +: avt_pkg::GainW];
			end
			rnd_c[r] = acc_s2[r] + avt_pkg::AccW'(2 ** (avt_pkg::FracW - 1));
			shr_c[r] = rnd_c[r][avt_pkg::AccW-1:avt_pkg::FracW];
			if (shr_c[r] > QMax) begin
				sat_c[r] = avt_pkg::CoordMax;
			end else if (shr_c[r] < QMin) begin
				sat_c[r] = avt_pkg::CoordMin;
			end else begin
				sat_c[r] = shr_c[r][avt_pkg::CoordW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s1 <= in_vtx.last;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[r][k] <= gain_c[r][k] * coord_c[k];
				end
			end
			last_s2 <= last_s1;
			for (int r = 0; r < 3; r++) begin
				acc_s2[r] <= avt_pkg::AccW'(prod_s1[r][0]) + avt_pkg::AccW'(prod_s1[r][1])
					+ avt_pkg::AccW'(prod_s1[r][2])
					+ (avt_pkg::AccW'(off_c[r]) <<< avt_pkg::FracW);
			end
			res_s3.last <= last_s2;
			res_s3.x    <= sat_c[0];
			res_s3.y    <= sat_c[1];
			res_s3.z    <= sat_c[2];
		end
	end

endmodule

### hw/rtl/avt_fifo.sv
// Short queue of transformed vertices between the front end and the back end.
module avt_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  avt_pkg::vtx_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output avt_pkg::vtx_t pop_data
);

	avt_pkg::vtx_t                mem_q [avt_pkg::FifoDepth];
	logic [avt_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [avt_pkg::FifoPtrW:0]   cnt_q;
	logic                         push, pop;

	assign push_ready = cnt_q != (avt_pkg::FifoPtrW + 1)'(avt_pkg::FifoDepth);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hw/rtl/avt_div.sv
// Three-lane restoring divider that forms the per-axis mean, one quotient bit per cycle.
module avt_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  avt_pkg::div_req_t                   req,
	input  logic [2:0][avt_pkg::SumW-1:0]       sums,
	output logic                                done,
	output logic [2:0][avt_pkg::CoordW-1:0]     quot
);

	localparam int StepW = $clog2(avt_pkg::SumW);

	logic                          busy_q;
	logic [StepW-1:0]              step_q;
	logic [avt_pkg::CntW-1:0]      dsr_q;
	logic [2:0]                    neg_q;
	logic [avt_pkg::SumW-1:0]      dvd_q [3];
	logic [avt_pkg::CntW-1:0]      rem_q [3];
	logic [avt_pkg::CntW:0]        trial_c [3];
	logic [avt_pkg::CntW:0]        diff_c [3];
	logic [avt_pkg::CoordW-1:0]    mag_c [3];

	assign done = !busy_q;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			trial_c[a] = {rem_q[a], dvd_q[a][avt_pkg::SumW-1]};
			diff_c[a]  = trial_c[a] - {1'b0, dsr_q};
			mag_c[a]   = dvd_q[a][avt_pkg::CoordW-1:0];
			quot[a]    = neg_q[a] ? (~mag_c[a] + 1'b1) : mag_c[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == StepW'(avt_pkg::SumW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dsr_q <= req.count;
			for (int a = 0; a < 3; a++) begin
				neg_q[a] <= sums[a][avt_pkg::SumW-1];
				dvd_q[a] <= sums[a][avt_pkg::SumW-1] ? (~sums[a] + 1'b1) : sums[a];
				rem_q[a] <= '0;
			end
		end else if (busy_q) begin
			for (int a = 0; a < 3; a++) begin
				if (!diff_c[a][avt_pkg::CntW]) begin
					rem_q[a] <= diff_c[a][avt_pkg::CntW-1:0];
					dvd_q[a] <= {dvd_q[a][avt_pkg::SumW-2:0], 1'b1};
				end else begin
					rem_q[a] <= trial_c[a][avt_pkg::CntW-1:0];
					dvd_q[a] <= {dvd_q[a][avt_pkg::SumW-2:0], 1'b0};
				end
			end
		end
	end

endmodule

### hw/rtl/avt_stats.sv
// Back end: tracks the bounding box and sums, and sequences the result items.
module avt_stats (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  avt_pkg::vtx_t                       in_vtx,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [avt_pkg::KindW-1:0]           out_kind,
	output logic [avt_pkg::DataW-1:0]           out_data,
	output logic                                out_last,
	output avt_pkg::div_req_t                   div_req,
	output logic [2:0][avt_pkg::SumW-1:0]       div_sums,
	input  logic                                div_done,
	input  logic [2:0][avt_pkg::CoordW-1:0]     div_quot
);

	localparam logic [1:0] StVtx  = 2'd0;
	localparam logic [1:0] StMin  = 2'd1;
	localparam logic [1:0] StMax  = 2'd2;
	localparam logic [1:0] StMean = 2'd3;

	logic [1:0]                       st_q;
	logic [avt_pkg::CntW-1:0]         cnt_q;
	avt_pkg::coord_t                  min_q [3];
	avt_pkg::coord_t                  max_q [3];
	logic signed [avt_pkg::SumW-1:0]  sum_q [3];
	logic                             out_valid_q;
	logic [avt_pkg::KindW-1:0]        out_kind_q;
	logic [avt_pkg::DataW-1:0]        out_data_q;
	logic                             out_last_q;

	avt_pkg::coord_t                  t_c [3];
	avt_pkg::coord_t                  nmin_c [3];
	avt_pkg::coord_t                  nmax_c [3];
	logic signed [avt_pkg::SumW-1:0]  nsum_c [3];
	logic [avt_pkg::CntW-1:0]         ncnt_c;
	logic                             room_c, out_free, take;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (st_q == StVtx) && out_free;
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	always_comb begin
		t_c[0] = in_vtx.x;
		t_c[1] = in_vtx.y;
		t_c[2] = in_vtx.z;
		room_c = cnt_q < avt_pkg::CntW'(avt_pkg::MaxVertices);
		ncnt_c = room_c ? cnt_q + 1'b1 : cnt_q;
		for (int a = 0; a < 3; a++) begin
			nmin_c[a] = (room_c && (t_c[a] < min_q[a])) ? t_c[a] : min_q[a];
			nmax_c[a] = (room_c && (t_c[a] > max_q[a])) ? t_c[a] : max_q[a];
			nsum_c[a] = room_c ? sum_q[a] + avt_pkg::SumW'(t_c[a]) : sum_q[a];
			div_sums[a] = nsum_c[a];
		end
		div_req.start = take && in_vtx.last;
		div_req.count = ncnt_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= StVtx;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			for (int a = 0; a < 3; a++) begin
				min_q[a] <= avt_pkg::CoordMax;
				max_q[a] <= avt_pkg::CoordMin;
				sum_q[a] <= '0;
			end
		end else begin
			case (st_q)
				StVtx: begin
					if (take) begin
						out_valid_q <= 1'b1;
						cnt_q       <= ncnt_c;
						for (int a = 0; a < 3; a++) begin
							min_q[a] <= nmin_c[a];
							max_q[a] <= nmax_c[a];
							sum_q[a] <= nsum_c[a];
						end
						if (in_vtx.last) begin
							st_q <= StMin;
						end
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				StMin: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						st_q        <= StMax;
					end
				end
				StMax: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						st_q        <= StMean;
					end
				end
				StMean: begin
					if (out_free && div_done) begin
						out_valid_q <= 1'b1;
						st_q        <= StVtx;
						cnt_q       <= '0;
						for (int a = 0; a < 3; a++) begin
							min_q[a] <= avt_pkg::CoordMax;
							max_q[a] <= avt_pkg::CoordMin;
							sum_q[a] <= '0;
						end
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					out_valid_q <= 1'b0;
					st_q        <= StVtx;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			StVtx: begin
				if (take) begin
					out_kind_q <= avt_pkg::KindVertex;
					out_data_q <= {in_vtx.z, in_vtx.y, in_vtx.x};
					out_last_q <= !in_vtx.last;
				end
			end
			StMin: begin
				if (out_free) begin
					out_kind_q <= avt_pkg::KindMin;
					out_data_q <= {min_q[2], min_q[1], min_q[0]};
					out_last_q <= 1'b0;
				end
			end
			StMax: begin
				if (out_free) begin
					out_kind_q <= avt_pkg::KindMax;
					out_data_q <= {max_q[2], max_q[1], max_q[0]};
					out_last_q <= 1'b0;
				end
			end
			StMean: begin
				if (out_free && div_done) begin
					out_kind_q <= avt_pkg::KindMean;
					out_data_q <= {div_quot[2], div_quot[1], div_quot[0]};
					out_last_q <= 1'b1;
				end
			end
			default: begin
				out_last_q <= 1'b0;
			end
		endcase
	end

endmodule

### hw/rtl/affine_vertex_transform_bbox.sv
// Top level of the affine vertex transform with running bounding box.
//
// Vertices enter on the s_axis channel, one item per vertex, with tlast on
// the final vertex of a mesh. Each vertex leaves on m_axis as a transformed
// vertex item (tuser kind 0). The final vertex is followed by the minimum,
// maximum and mean items (kinds 1, 2, 3); m_axis_tlast marks the last item
// caused by each input vertex. A vertex passes through the transform
// pipeline, the queue and the output register. Ordinary vertices flow at
// one per cycle while m_axis is ready. After a final vertex the back end
// accepts nothing until it has sent the min, max and mean items, the mean
// waiting on the 45-step mean divider. The cfg channel writes registers
// 0 to 5 and is always ready; the user must write it only while the block
// is idle, which the block itself does not enforce. Reset restores the
// identity transform and clears the statistics. When m_axis stalls, results
// wait in the output register, the queue fills and then s_axis_tready drops.
module affine_vertex_transform_bbox (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [avt_pkg::DataW-1:0]     s_axis_tdata,  // in_x, in_y, in_z
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [avt_pkg::DataW-1:0]     m_axis_tdata,  // out_x, out_y, out_z
	output logic [avt_pkg::KindW-1:0]     m_axis_tuser,  // kind
	output logic                          m_axis_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [avt_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [avt_pkg::CfgDataW-1:0]  cfg_data
);

	logic [2:0][avt_pkg::CfgDataW-1:0]  gains_q;
	logic [2:0][avt_pkg::CoordW-1:0]    offs_q;
	avt_pkg::vtx_t                      in_vtx, xf_vtx, q_vtx;
	logic                               xf_valid, xf_ready, q_valid, q_ready;
	avt_pkg::div_req_t                  div_req;
	logic [2:0][avt_pkg::SumW-1:0]      div_sums;
	logic                               div_done;
	logic [2:0][avt_pkg::CoordW-1:0]    div_quot;

	assign cfg_ready   = 1'b1;
	assign in_vtx.x    = s_axis_tdata[avt_pkg::CoordW-1:0];
	assign in_vtx.y    = s_axis_tdata[2*avt_pkg::CoordW-1:avt_pkg::CoordW];
	assign in_vtx.z    = s_axis_tdata[3*avt_pkg::CoordW-1:2*avt_pkg::CoordW];
	assign in_vtx.last = s_axis_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q[0] <= avt_pkg::CfgDataW'(avt_pkg::GainOne);
			gains_q[1] <= avt_pkg::CfgDataW'(avt_pkg::GainOne) << avt_pkg::GainW;
			gains_q[2] <= avt_pkg::CfgDataW'(avt_pkg::GainOne) << (2 * avt_pkg::GainW);
			offs_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				avt_pkg::RegRowX: gains_q[0] <= cfg_data;
				avt_pkg::RegRowY: gains_q[1] <= cfg_data;
				avt_pkg::RegRowZ: gains_q[2] <= cfg_data;
				avt_pkg::RegOffX: offs_q[0] <= cfg_data[avt_pkg::CoordW-1:0];
				avt_pkg::RegOffY: offs_q[1] <= cfg_data[avt_pkg::CoordW-1:0];
				avt_pkg::RegOffZ: offs_q[2] <= cfg_data[avt_pkg::CoordW-1:0];
				default: begin
				end
			endcase
		end
	end

	avt_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains_q),
		.offs      (offs_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_vtx    (in_vtx),
		.out_valid (xf_valid),
		.out_ready (xf_ready),
		.out_vtx   (xf_vtx)
	);

	avt_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (xf_valid),
		.push_ready (xf_ready),
		.push_data  (xf_vtx),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_vtx)
	);

	avt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sums   (div_sums),
		.done   (div_done),
		.quot   (div_quot)
	);

	avt_stats u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_vtx    (q_vtx),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (m_axis_tuser),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.div_req   (div_req),
		.div_sums  (div_sums),
		.div_done  (div_done),
		.div_quot  (div_quot)
	);

endmodule
